FILE: rtl/moc_pkg.sv
// ----------------------------------------------------------------------------
// moc_pkg: shared types and constants for the circle merge block
// Payload words, stored blob entry layout and fixed-point constants.
// ----------------------------------------------------------------------------
package moc_pkg;

   localparam int CoordW  = 12;
   localparam int AreaW   = 24;
   localparam int FactorW = 12;
   localparam int RadW    = 20;   // Q8 radius, floor sqrt of a 39-bit value
   localparam int SqInW   = 39;   // (area * 1/pi in Q32) >> 16
   localparam int NumW    = 37;   // coordinate * area, summed over two blobs
   localparam int SumW    = 25;   // two areas summed

   localparam logic [30:0]       INV_PI_Q32 = 31'd1367130551;
   localparam logic [AreaW-1:0]  AREA_MAX   = 24'hFFFFFF;
   localparam logic [63:0]       FAR_LIMIT  = 64'd1 << 29;
   localparam logic [FactorW-1:0] FACTOR_RESET = 12'd256;

   typedef struct packed {
      logic [CoordW-1:0] centre_x;
      logic [CoordW-1:0] centre_y;
      logic [AreaW-1:0]  blob_area;
      logic              last_blob;
   } req_type;

   typedef struct packed {
      logic [CoordW-1:0] merged_x;
      logic [CoordW-1:0] merged_y;
      logic [AreaW-1:0]  merged_area;
      logic              final_result;
   } rsp_type;

   typedef struct packed {
      logic [CoordW-1:0] x;
      logic [CoordW-1:0] y;
      logic [AreaW-1:0]  area;
      logic [RadW-1:0]   radius;
   } entry_type;

endpackage

FILE: rtl/moc_sqrt.sv
// ----------------------------------------------------------------------------
// moc_sqrt: iterative integer square root
// One result bit per cycle, floor sqrt of a 39-bit value.
// ----------------------------------------------------------------------------
module moc_sqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [moc_pkg::SqInW-1:0]    value,
   output logic                         done,
   output logic [moc_pkg::RadW-1:0]     root
);
   import moc_pkg::*;

   logic [39:0] v_ff, v_in, res_ff, res_in, bit_ff, bit_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [39:0] trial;

   always_comb begin
      trial   = res_ff + bit_ff;
      v_in    = v_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         v_in    = {1'b0, value};
         res_in  = '0;
         bit_in  = 40'd1 << 38;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (v_ff >= trial) begin
            v_in   = v_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(RadW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      v_ff   <= v_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = res_ff[RadW-1:0];

endmodule

FILE: rtl/moc_div.sv
// ----------------------------------------------------------------------------
// moc_div: iterative restoring divider for the weighted centroid
// Quotient known below 4096; one quotient bit per cycle.
// ----------------------------------------------------------------------------
module moc_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [moc_pkg::NumW-1:0]      num,
   input  logic [moc_pkg::SumW-1:0]      den,
   output logic                          done,
   output logic [moc_pkg::CoordW-1:0]    quot
);
   import moc_pkg::*;

   logic [NumW-1:0]   rem_ff, rem_in, dsh_ff, dsh_in;
   logic [CoordW-1:0] q_ff, q_in;
   logic [3:0]        cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = num;
         dsh_in  = NumW'({den, 11'b0});
         q_in    = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= dsh_ff) begin
            rem_in = rem_ff - dsh_ff;
            q_in   = {q_ff[CoordW-2:0], 1'b1};
         end else begin
            q_in   = {q_ff[CoordW-2:0], 1'b0};
         end
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'(CoordW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

FILE: rtl/moc_mem.sv
// ----------------------------------------------------------------------------
// moc_mem: blob store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module moc_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                  clock,
   input  logic                  we,
   input  logic [AW-1:0]         waddr,
   input  moc_pkg::entry_type    wdata,
   input  logic [AW-1:0]         raddr,
   output moc_pkg::entry_type    rdata
);
   import moc_pkg::*;

   entry_type mem [DEPTH];
   entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/merge_overlapping_circles.sv
// ----------------------------------------------------------------------------
// merge_overlapping_circles: collect blobs, merge overlapping ones, emit rest
// Sequencer around one shared multiplier, a sqrt unit and a divider.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel (req_valid / req_stall / req_data) carries one blob word.
//    Words are stored up to MAX_BLOBS; words past capacity are dropped.
//  - A stored word goes through the area/pi product, the sqrt for the
//    radius and the store write; a dropped non-last word leaves it idle.
//    req_stall stays high while the block works.
//  - A word with last_blob set starts the merge pass. Each ordered pair
//    test runs on the shared multiplier; a merge runs two divides and a
//    sqrt, and the scan restarts from the first pair after each merge.
//    Worst case is roughly N^3 pair tests for N stored blobs.
//  - Then each remaining blob goes out on rsp (rsp_valid / rsp_stall /
//    rsp_data), final_result on the last one. A stalled rsp word holds
//    until taken, then the next is read; after the last the list clears.
//  - csr channel writes closeness_factor (Q4.8); csr_ready is always high.
//  - reset (synchronous) empties the list and sets the factor to 1.0.
// ----------------------------------------------------------------------------
module merge_overlapping_circles #(
   parameter int MAX_BLOBS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  moc_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output moc_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [moc_pkg::FactorW-1:0]         csr_data
);
   import moc_pkg::*;

   localparam int CW = $clog2(MAX_BLOBS + 1);
   localparam int IW = $clog2(MAX_BLOBS);

   typedef enum logic [4:0] {
      S_IDLE, S_RMUL, S_RSQ, S_RWAIT,
      S_SCAN, S_RD_B, S_LAT_B, S_MX, S_MY, S_MT, S_MT2, S_CMP,
      S_GX1, S_GX2, S_GX3, S_DXS, S_DXW,
      S_GY1, S_GY2, S_GY3, S_DYS, S_DYW,
      S_RD_L, S_LAT_L,
      S_E_RD, S_E_LD, S_E_WAIT
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [IW-1:0]      a_ff, a_in, b_ff, b_in;
   logic [CoordW-1:0]  x_ff, x_in, y_ff, y_in;
   logic [AreaW-1:0]   area_ff, area_in;
   logic               last_ff, last_in, merging_ff, merging_in;
   entry_type          ea_ff, ea_in, eb_ff, eb_in;
   logic [NumW-1:0]    acc_ff, acc_in;
   logic               far_ff, far_in;
   logic [FactorW-1:0] factor_ff, factor_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic [63:0]        prod_ff, prod_in;

   logic [31:0]        mul_a, mul_b;
   logic               mem_we;
   logic [IW-1:0]      mem_waddr, mem_raddr;
   entry_type          mem_wdata, mem_rdata;
   logic               sq_start, sq_done, div_start, div_done;
   logic [RadW-1:0]    sq_root;
   logic [CoordW-1:0]  div_quot;
   logic [NumW-1:0]    div_num;

   logic [CoordW-1:0]  dx, dy;
   logic [SumW-1:0]    area_sum;
   logic               a_is_last, b_is_last, close;
   logic [CW-1:0]      count_dec;

   // pair geometry from the two latched entries
   assign dx       = (ea_ff.x >= eb_ff.x) ? ea_ff.x - eb_ff.x : eb_ff.x - ea_ff.x;
   assign dy       = (ea_ff.y >= eb_ff.y) ? ea_ff.y - eb_ff.y : eb_ff.y - ea_ff.y;
   assign area_sum = SumW'(ea_ff.area) + SumW'(eb_ff.area);
   assign a_is_last = (CW'(a_ff) + CW'(1)) == count_ff;
   assign b_is_last = (CW'(b_ff) + CW'(1)) == count_ff;
   assign count_dec = count_ff - CW'(1);
   // squared distance shifted by 32 against squared threshold
   assign close     = far_ff || ({7'b0, acc_ff[24:0], 32'b0} < prod_ff);
   assign div_num   = acc_ff;

   // shared multiplier, product registered every cycle
   assign prod_in = 64'(mul_a) * 64'(mul_b);

   moc_mem #(.DEPTH(MAX_BLOBS), .AW(IW)) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   moc_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .value (prod_ff[SqInW+15:16]),
      .done  (sq_done),
      .root  (sq_root)
   );

   moc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (area_sum),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      area_in      = area_ff;
      last_in      = last_ff;
      merging_in   = merging_ff;
      ea_in        = ea_ff;
      eb_in        = eb_ff;
      acc_in       = acc_ff;
      far_in       = far_ff;
      factor_in    = factor_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mul_a        = '0;
      mul_b        = '0;
      mem_we       = 1'b0;
      mem_waddr    = a_ff;
      mem_wdata    = '{x: x_ff, y: y_ff, area: area_ff, radius: sq_root};
      mem_raddr    = a_ff;
      sq_start     = 1'b0;
      div_start    = 1'b0;

      if (csr_valid) begin
         factor_in = csr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               x_in       = req_data.centre_x;
               y_in       = req_data.centre_y;
               area_in    = req_data.blob_area;
               last_in    = req_data.last_blob;
               merging_in = 1'b0;
               a_in       = '0;
               b_in       = '0;
               if (count_ff < CW'(MAX_BLOBS)) begin
                  state_in = S_RMUL;
               end else if (req_data.last_blob) begin
                  state_in = S_SCAN;
               end
            end
         end
         S_RMUL: begin
            mul_a    = 32'(area_ff);
            mul_b    = 32'(INV_PI_Q32);
            state_in = S_RSQ;
         end
         S_RSQ: begin
            sq_start = 1'b1;
            state_in = S_RWAIT;
         end
         S_RWAIT: begin
            if (sq_done) begin
               mem_we = 1'b1;
               if (merging_ff) begin
                  // merged blob into slot a, then pull last blob into slot b
                  mem_waddr = a_ff;
                  count_in  = count_dec;
                  state_in  = S_RD_L;
               end else begin
                  mem_waddr = count_ff[IW-1:0];
                  count_in  = count_ff + CW'(1);
                  a_in      = '0;
                  b_in      = '0;
                  state_in  = last_ff ? S_SCAN : S_IDLE;
               end
            end
         end
         S_SCAN: begin
            mem_raddr = a_ff;
            if (count_ff < CW'(2)) begin
               a_in     = '0;
               state_in = S_E_RD;
            end else if (a_ff == b_ff) begin
               // skip self pair, advance
               if (b_is_last) begin
                  b_in = '0;
                  a_in = a_ff + IW'(1);
                  if (a_is_last) begin
                     a_in     = '0;
                     state_in = S_E_RD;
                  end
               end else begin
                  b_in = b_ff + IW'(1);
               end
            end else begin
               state_in = S_RD_B;
            end
         end
         S_RD_B: begin
            mem_raddr = b_ff;
            ea_in     = mem_rdata;
            state_in  = S_LAT_B;
         end
         S_LAT_B: begin
            eb_in    = mem_rdata;
            state_in = S_MX;
         end
         S_MX: begin
            mul_a    = 32'(dx);
            mul_b    = 32'(dx);
            state_in = S_MY;
         end
         S_MY: begin
            mul_a    = 32'(dy);
            mul_b    = 32'(dy);
            acc_in   = NumW'(prod_ff[23:0]);
            state_in = S_MT;
         end
         S_MT: begin
            mul_a    = 32'(ea_ff.radius) + 32'(eb_ff.radius);
            mul_b    = 32'(factor_ff);
            acc_in   = acc_ff + NumW'(prod_ff[23:0]);
            state_in = S_MT2;
         end
         S_MT2: begin
            // threshold in prod_ff; square its low bits, flag far if it does not fit
            mul_a    = 32'(prod_ff[28:0]);
            mul_b    = 32'(prod_ff[28:0]);
            far_in   = prod_ff >= FAR_LIMIT;
            state_in = S_CMP;
         end
         S_CMP: begin
            if (close) begin
               state_in = S_GX1;
            end else if (b_is_last) begin
               b_in = '0;
               a_in = a_ff + IW'(1);
               state_in = S_SCAN;
               if (a_is_last) begin
                  a_in     = '0;
                  state_in = S_E_RD;
               end
            end else begin
               b_in     = b_ff + IW'(1);
               state_in = S_SCAN;
            end
         end
         S_GX1: begin
            mul_a    = 32'(ea_ff.x);
            mul_b    = 32'(ea_ff.area);
            area_in  = area_sum[AreaW] ? AREA_MAX : area_sum[AreaW-1:0];
            state_in = S_GX2;
         end
         S_GX2: begin
            mul_a    = 32'(eb_ff.x);
            mul_b    = 32'(eb_ff.area);
            acc_in   = prod_ff[NumW-1:0];
            state_in = S_GX3;
         end
         S_GX3: begin
            acc_in   = acc_ff + prod_ff[NumW-1:0];
            state_in = S_DXS;
         end
         S_DXS: begin
            div_start = 1'b1;
            state_in  = S_DXW;
         end
         S_DXW: begin
            if (div_done) begin
               x_in     = (area_sum == '0) ? ea_ff.x : div_quot;
               state_in = S_GY1;
            end
         end
         S_GY1: begin
            mul_a    = 32'(ea_ff.y);
            mul_b    = 32'(ea_ff.area);
            state_in = S_GY2;
         end
         S_GY2: begin
            mul_a    = 32'(eb_ff.y);
            mul_b    = 32'(eb_ff.area);
            acc_in   = prod_ff[NumW-1:0];
            state_in = S_GY3;
         end
         S_GY3: begin
            acc_in   = acc_ff + prod_ff[NumW-1:0];
            state_in = S_DYS;
         end
         S_DYS: begin
            div_start = 1'b1;
            state_in  = S_DYW;
         end
         S_DYW: begin
            if (div_done) begin
               y_in       = (area_sum == '0) ? ea_ff.y : div_quot;
               merging_in = 1'b1;
               state_in   = S_RMUL;
            end
         end
         S_RD_L: begin
            mem_raddr = count_ff[IW-1:0];
            state_in  = S_LAT_L;
         end
         S_LAT_L: begin
            mem_we    = 1'b1;
            mem_waddr = b_ff;
            mem_wdata = mem_rdata;
            a_in      = '0;
            b_in      = '0;
            state_in  = S_SCAN;
         end
         S_E_RD: begin
            mem_raddr = a_ff;
            state_in  = S_E_LD;
         end
         S_E_LD: begin
            rsp_data_in.merged_x     = mem_rdata.x;
            rsp_data_in.merged_y     = mem_rdata.y;
            rsp_data_in.merged_area  = mem_rdata.area;
            rsp_data_in.final_result = a_is_last;
            rsp_valid_in = 1'b1;
            state_in     = S_E_WAIT;
         end
         S_E_WAIT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (rsp_data_ff.final_result) begin
                  count_in = '0;
                  a_in     = '0;
                  state_in = S_IDLE;
               end else begin
                  a_in     = a_ff + IW'(1);
                  state_in = S_E_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      y_ff        <= y_in;
      area_ff     <= area_in;
      last_ff     <= last_in;
      ea_ff       <= ea_in;
      eb_ff       <= eb_in;
      acc_ff      <= acc_in;
      far_ff      <= far_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         a_ff         <= '0;
         b_ff         <= '0;
         merging_ff   <= 1'b0;
         factor_ff    <= FACTOR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         a_ff         <= a_in;
         b_ff         <= b_in;
         merging_ff   <= merging_in;
         factor_ff    <= factor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

endmodule

FILE: rtl/moc_checker.sv
// ----------------------------------------------------------------------------
// moc_checker: port-level checks for the circle merge block
// Watches handshakes and sequencing as seen on the top level ports.
// ----------------------------------------------------------------------------
module moc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input moc_pkg::req_type            req_data,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input moc_pkg::rsp_type            rsp_data
);
   import moc_pkg::*;

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp word changed while stalled");

   // drop results at reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // no new word accepted while results are out
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("req accepted during emission");

   // a last word always starts a merge pass
   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.last_blob |=> req_stall)
      else $error("block idle after last word");

endmodule

bind merge_overlapping_circles moc_checker u_moc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
